/* rtl/n2k_gateway_tx_framer_macros.svh */
// Assertion helpers used by the framer checker.
`ifndef N2K_GATEWAY_TX_FRAMER_MACROS_SVH
`define N2K_GATEWAY_TX_FRAMER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define N2K_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define N2K_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/n2k_gtf_pkg.sv */
`timescale 1ns / 1ps
package n2k_gtf_pkg;

  localparam logic [7:0] MAX_PAYLOAD  = 8'd223;
  localparam logic [7:0] LEN_OVERHEAD = 8'd6;

  localparam logic       TX_EN_RST = 1'b1;
  localparam logic [7:0] ESC_RST   = 8'h10;
  localparam logic [7:0] START_RST = 8'h02;
  localparam logic [7:0] ETX_RST   = 8'h03;
  localparam logic [7:0] MSG_RST   = 8'h94;

  typedef enum logic {
    OP_HEADER  = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    CFG_TX_EN = 3'd0,
    CFG_ESC   = 3'd1,
    CFG_START = 3'd2,
    CFG_ETX   = 3'd3,
    CFG_MSG   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic       tx_en;
    logic [7:0] esc;
    logic [7:0] start;
    logic [7:0] etx;
    logic [7:0] msg;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  prio;
    logic [23:0] pgn;
    logic [7:0]  dest;
    logic [7:0]  plen;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
    logic       frame_end;
  } result_t;

  typedef enum logic [13:0] {
    SL_ESC  = 14'b00000000000001,
    SL_STX  = 14'b00000000000010,
    SL_CODE = 14'b00000000000100,
    SL_LEN  = 14'b00000000001000,
    SL_PRIO = 14'b00000000010000,
    SL_PGN0 = 14'b00000000100000,
    SL_PGN1 = 14'b00000001000000,
    SL_PGN2 = 14'b00000010000000,
    SL_DEST = 14'b00000100000000,
    SL_PLEN = 14'b00001000000000,
    SL_DATA = 14'b00010000000000,
    SL_CSUM = 14'b00100000000000,
    SL_CESC = 14'b01000000000000,
    SL_ETX  = 14'b10000000000000
  } slot_t;

endpackage

/* rtl/n2k_gateway_tx_framer.sv */
`timescale 1ns / 1ps
// Gateway transmit framer. A header request opens a frame and produces the
// escape and start bytes, eight body bytes and, for an empty payload, the
// checksum and closing bytes; each payload request produces its byte and,
// on the last one, the trailer. Body and checksum bytes equal to the escape
// code are sent twice. The output register delivers one byte per cycle
// while the receiver is ready; a request produces one or two bytes for a
// payload byte, up to six with the trailer, ten to twenty-two for a header.
// A request that produces nothing is taken and dropped by the sequencer. One
// input request is buffered while the previous one is still being framed.
// Configuration is meant to be written only while the framer is idle.
module n2k_gateway_tx_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // priority_req[2:0], pgn[26:3], destination[34:27],
                                     // payload_length[42:35], data_byte[50:43], zero fill
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,  // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import n2k_gtf_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   hold_item;
  logic    hold_valid;
  logic    work_free;
  logic    out_can;
  logic    res_load;
  result_t res;
  result_t out_res;

  assign in_item.op   = op_t'(s_axis_tuser);
  assign in_item.prio = s_axis_tdata[2:0];
  assign in_item.pgn  = s_axis_tdata[26:3];
  assign in_item.dest = s_axis_tdata[34:27];
  assign in_item.plen = s_axis_tdata[42:35];
  assign in_item.data = s_axis_tdata[50:43];

  n2k_gtf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  n2k_gtf_inbuf u_inbuf (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .take       (work_free),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  n2k_gtf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .work_free  (work_free),
    .out_can    (out_can),
    .res_load   (res_load),
    .res        (res)
  );

  n2k_gtf_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_can   (out_can),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = out_res.out_byte;
  assign m_axis_tlast = out_res.last_in_run;
  assign m_axis_tuser = out_res.frame_end;

endmodule

/* rtl/n2k_gtf_cfg.sv */
`timescale 1ns / 1ps
module n2k_gtf_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output n2k_gtf_pkg::cfg_t cfg
);
  import n2k_gtf_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tx_en <= TX_EN_RST;
      cfg.esc   <= ESC_RST;
      cfg.start <= START_RST;
      cfg.etx   <= ETX_RST;
      cfg.msg   <= MSG_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TX_EN: cfg.tx_en <= cfg_data[0];
        CFG_ESC:   cfg.esc   <= cfg_data;
        CFG_START: cfg.start <= cfg_data;
        CFG_ETX:   cfg.etx   <= cfg_data;
        CFG_MSG:   cfg.msg   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/n2k_gtf_inbuf.sv */
`timescale 1ns / 1ps
module n2k_gtf_inbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  n2k_gtf_pkg::item_t in_item,
  input  logic               take,
  output logic               hold_valid,
  output n2k_gtf_pkg::item_t hold_item
);
  import n2k_gtf_pkg::*;

  logic accept;

  assign in_ready = !hold_valid || take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item <= in_item;
    end
  end

endmodule

/* rtl/n2k_gtf_seq.sv */
`timescale 1ns / 1ps
module n2k_gtf_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  n2k_gtf_pkg::cfg_t    cfg,
  input  logic                 hold_valid,
  input  n2k_gtf_pkg::item_t   hold_item,
  output logic                 work_free,
  input  logic                 out_can,
  output logic                 res_load,
  output n2k_gtf_pkg::result_t res
);
  import n2k_gtf_pkg::*;

  logic       busy;
  item_t      item;
  slot_t      slot;
  slot_t      slot_next;
  logic       dup;
  logic [7:0] sum;
  logic [7:0] bytes_left;
  logic       frame_open;

  logic [7:0] len_sat;
  logic [7:0] cur_byte;
  logic       is_body;
  logic       drop;
  logic       need_dup;
  logic       emit;
  logic       advance;
  logic       done;
  logic       finish;

  always_comb begin
    len_sat = (item.plen > MAX_PAYLOAD) ? MAX_PAYLOAD : item.plen;

    case (slot)
      SL_ESC:  cur_byte = cfg.esc;
      SL_STX:  cur_byte = cfg.start;
      SL_CODE: cur_byte = cfg.msg;
      SL_LEN:  cur_byte = len_sat + LEN_OVERHEAD;
      SL_PRIO: cur_byte = {5'd0, item.prio};
      SL_PGN0: cur_byte = item.pgn[7:0];
      SL_PGN1: cur_byte = item.pgn[15:8];
      SL_PGN2: cur_byte = item.pgn[23:16];
      SL_DEST: cur_byte = item.dest;
      SL_PLEN: cur_byte = len_sat;
      SL_DATA: cur_byte = item.data;
      SL_CSUM: cur_byte = 8'd0 - sum;
      SL_CESC: cur_byte = cfg.esc;
      SL_ETX:  cur_byte = cfg.etx;
      default: cur_byte = cfg.esc;
    endcase

    is_body = slot inside {SL_CODE, SL_LEN, SL_PRIO, SL_PGN0, SL_PGN1, SL_PGN2,
                           SL_DEST, SL_PLEN, SL_DATA};

    // A header is dropped only while transmit is off; a payload byte also when
    // no frame is waiting for more payload.
    drop = busy && (((slot == SL_ESC) && !cfg.tx_en) ||
                    ((slot == SL_DATA) &&
                     (!cfg.tx_en || !frame_open || (bytes_left == 8'd0))));

    need_dup = (is_body || (slot == SL_CSUM)) && (cur_byte == cfg.esc) && !dup;
    emit     = busy && !drop && out_can;
    advance  = emit && !need_dup;

    done = 1'b0;
    case (slot)
      SL_ESC:  slot_next = SL_STX;
      SL_STX:  slot_next = SL_CODE;
      SL_CODE: slot_next = SL_LEN;
      SL_LEN:  slot_next = SL_PRIO;
      SL_PRIO: slot_next = SL_PGN0;
      SL_PGN0: slot_next = SL_PGN1;
      SL_PGN1: slot_next = SL_PGN2;
      SL_PGN2: slot_next = SL_DEST;
      SL_DEST: slot_next = SL_PLEN;
      SL_PLEN: begin
        slot_next = SL_CSUM;
        done      = (len_sat != 8'd0);
      end
      SL_DATA: begin
        slot_next = SL_CSUM;
        done      = (bytes_left != 8'd1);
      end
      SL_CSUM: slot_next = SL_CESC;
      SL_CESC: slot_next = SL_ETX;
      SL_ETX: begin
        slot_next = SL_ESC;
        done      = 1'b1;
      end
      default: begin
        slot_next = SL_ESC;
        done      = 1'b1;
      end
    endcase

    finish    = drop || (advance && done);
    work_free = !busy || finish;

    res_load        = emit;
    res.out_byte    = cur_byte;
    res.last_in_run = advance && done;
    res.frame_end   = (slot == SL_ETX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      slot       <= SL_ESC;
      dup        <= 1'b0;
      sum        <= 8'd0;
      bytes_left <= 8'd0;
      frame_open <= 1'b0;
    end else begin
      if (emit && (slot == SL_ESC)) begin
        sum        <= 8'd0;
        frame_open <= 1'b1;
        bytes_left <= len_sat;
      end
      if (advance && is_body) begin
        sum <= sum + cur_byte;
      end
      if (advance && (slot == SL_DATA)) begin
        bytes_left <= bytes_left - 8'd1;
      end
      if (advance && (slot == SL_ETX)) begin
        frame_open <= 1'b0;
        bytes_left <= 8'd0;
      end
      if (work_free && hold_valid) begin
        busy <= 1'b1;
        slot <= (hold_item.op == OP_HEADER) ? SL_ESC : SL_DATA;
        dup  <= 1'b0;
      end else begin
        if (finish) begin
          busy <= 1'b0;
        end
        if (emit) begin
          dup <= need_dup;
          if (advance) begin
            slot <= slot_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (work_free && hold_valid) begin
      item <= hold_item;
    end
  end

endmodule

/* rtl/n2k_gtf_outreg.sv */
`timescale 1ns / 1ps
module n2k_gtf_outreg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_load,
  input  n2k_gtf_pkg::result_t res,
  output logic                 out_can,
  output logic                 out_valid,
  input  logic                 out_ready,
  output n2k_gtf_pkg::result_t out_res
);
  import n2k_gtf_pkg::*;

  assign out_can = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

endmodule

/* rtl/n2k_gtf_checker.sv */
`timescale 1ns / 1ps
`include "n2k_gateway_tx_framer_macros.svh"
module n2k_gtf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  `N2K_ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output byte changed")
  `N2K_ASSERT_NOW(a_end_is_last, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "closing byte not marked last")
  `N2K_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "configuration write refused")
  `N2K_ASSERT_NEXT(a_reset_state, clk, 1'b0, rst, !m_axis_tvalid && s_axis_tready, "framer not empty after reset")

endmodule

bind n2k_gateway_tx_framer n2k_gtf_checker u_n2k_gtf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import n2k_gtf_pkg::*;

  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  n2k_gateway_tx_framer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  cfg_t       tx_cfg;
  logic [7:0] run_sum;
  logic [7:0] bytes_due;
  logic       in_frame;
  result_t    run_bytes[$];
  result_t    wire_q[$];
  result_t    wire_exp;

  int errors = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  logic rx_hold = 1'b0;
  logic rx_quiet = 1'b0;
  logic tx_quiet = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic void push_byte(logic [7:0] b, logic fe);
    result_t r;
    r.out_byte    = b;
    r.last_in_run = 1'b0;
    r.frame_end   = fe;
    run_bytes.push_back(r);
  endfunction

  function automatic void push_body(logic [7:0] b);
    if (b == tx_cfg.esc) push_byte(b, 1'b0);
    push_byte(b, 1'b0);
    run_sum = run_sum + b;
  endfunction

  function automatic void push_trailer();
    logic [7:0] ck;
    ck = 8'h00 - run_sum;
    if (ck == tx_cfg.esc) push_byte(ck, 1'b0);
    push_byte(ck, 1'b0);
    push_byte(tx_cfg.esc, 1'b0);
    push_byte(tx_cfg.etx, 1'b1);
    in_frame  = 1'b0;
    bytes_due = 8'd0;
  endfunction

  // Works out the wire bytes one accepted request produces.
  function automatic void frame_item(item_t it);
    logic [7:0] len;
    result_t r;
    run_bytes.delete();
    if (tx_cfg.tx_en) begin
      if (it.op == OP_HEADER) begin
        len       = (it.plen > MAX_PAYLOAD) ? MAX_PAYLOAD : it.plen;
        run_sum   = 8'd0;
        in_frame  = 1'b1;
        bytes_due = len;
        push_byte(tx_cfg.esc, 1'b0);
        push_byte(tx_cfg.start, 1'b0);
        push_body(tx_cfg.msg);
        push_body(len + LEN_OVERHEAD);
        push_body({5'b0, it.prio});
        push_body(it.pgn[7:0]);
        push_body(it.pgn[15:8]);
        push_body(it.pgn[23:16]);
        push_body(it.dest);
        push_body(len);
        if (bytes_due == 8'd0) push_trailer();
      end else if (in_frame && bytes_due != 8'd0) begin
        push_body(it.data);
        bytes_due = bytes_due - 8'd1;
        if (bytes_due == 8'd0) push_trailer();
      end
    end
    if (run_bytes.size() > 0) begin
      r = run_bytes.pop_back();
      r.last_in_run = 1'b1;
      run_bytes.push_back(r);
    end
    foreach (run_bytes[i]) wire_q.push_back(run_bytes[i]);
  endfunction

  function automatic item_t hdr_item(logic [2:0] p, logic [23:0] g, logic [7:0] d,
                                     logic [7:0] n);
    item_t it;
    it.op   = OP_HEADER;
    it.prio = p;
    it.pgn  = g;
    it.dest = d;
    it.plen = n;
    it.data = 8'($urandom);
    return it;
  endfunction

  function automatic item_t pay_item(logic [7:0] b);
    item_t it;
    it.op   = OP_PAYLOAD;
    it.prio = 3'($urandom);
    it.pgn  = 24'($urandom);
    it.dest = 8'($urandom);
    it.plen = 8'($urandom);
    it.data = b;
    return it;
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    if (errors <= 50) $display("mismatch %s: got %02h expected %02h", what, got, want);
  endtask

  task automatic send_item(item_t it);
    int gap;
    gap = tx_quiet ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, it.data, it.plen, it.dest, it.pgn, it.prio};
    s_axis_tuser  <= it.op;
    do @(posedge clk); while (!s_axis_tready);
    frame_item(it);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (wire_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TX_EN: tx_cfg.tx_en = val[0];
      CFG_ESC:   tx_cfg.esc   = val;
      CFG_START: tx_cfg.start = val;
      CFG_ETX:   tx_cfg.etx   = val;
      CFG_MSG:   tx_cfg.msg   = val;
      default: ;
    endcase
  endtask

  // Payload byte that makes the frame checksum come out equal to the escape code.
  function automatic logic [7:0] csum_hits_esc();
    return 8'h00 - tx_cfg.esc - run_sum;
  endfunction

  task automatic test_default_frames();
    send_item(hdr_item(3'd0, 24'h000000, 8'h00, 8'd0));
    send_item(hdr_item(3'd7, 24'hffffff, 8'hff, 8'd3));
    send_item(pay_item(8'h10));
    send_item(pay_item(8'hff));
    send_item(pay_item(csum_hits_esc()));
    send_item(pay_item(8'h00));
    send_item(hdr_item(3'd5, 24'h01f004, 8'h23, 8'd5));
    send_item(pay_item(8'h55));
    send_item(pay_item(8'haa));
    send_item(hdr_item(3'd2, 24'h01f801, 8'hff, 8'd1));
    send_item(pay_item(8'h00));
    send_item(hdr_item(3'd0, 24'h101010, 8'h10, 8'd10));
    for (int k = 0; k < 10; k++) send_item(pay_item(8'($urandom)));
    send_item(hdr_item(3'd6, 24'h123456, 8'h10, 8'd16));
    send_item(pay_item(8'h10));
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_ESC, 8'h00);
    write_reg(CFG_START, 8'hff);
    write_reg(CFG_ETX, 8'h00);
    write_reg(CFG_MSG, 8'h00);
    send_item(hdr_item(3'd0, 24'h000100, 8'h00, 8'd0));
    send_item(hdr_item(3'd1, 24'h00ff00, 8'h00, 8'd2));
    send_item(pay_item(8'h00));
    send_item(pay_item(csum_hits_esc()));
    write_reg(CFG_ESC, 8'hff);
    write_reg(CFG_START, 8'h00);
    write_reg(CFG_ETX, 8'hff);
    write_reg(CFG_MSG, 8'hff);
    send_item(hdr_item(3'd7, 24'hff00ff, 8'hff, 8'd2));
    send_item(pay_item(8'hff));
    send_item(pay_item(csum_hits_esc()));
    write_reg(CFG_ESC, ESC_RST);
    write_reg(CFG_START, START_RST);
    write_reg(CFG_ETX, ETX_RST);
    write_reg(CFG_MSG, MSG_RST);
  endtask

  task automatic test_transmit_disabled();
    send_item(hdr_item(3'd3, 24'h00ee00, 8'h42, 8'd3));
    send_item(pay_item(8'h11));
    write_reg(CFG_TX_EN, 1'b0);
    send_item(pay_item(8'h22));
    send_item(hdr_item(3'd1, 24'h000001, 8'h01, 8'd0));
    send_item(pay_item(8'h33));
    write_reg(CFG_TX_EN, TX_EN_RST);
    send_item(pay_item(8'h44));
    send_item(pay_item(8'h10));
  endtask

  task automatic test_payload_saturation();
    send_item(hdr_item(3'd4, 24'h0ef000, 8'h80, 8'd255));
    for (int k = 0; k < MAX_PAYLOAD; k++) send_item(pay_item(8'($urandom)));
    send_item(pay_item(8'h77));
  endtask

  task automatic random_frame();
    int r;
    int n;
    int cut;
    logic [7:0] b;
    logic [7:0] d;
    r = $urandom_range(0, 99);
    if (r < 75) n = $urandom_range(0, 8);
    else if (r < 93) n = $urandom_range(9, 40);
    else if (r < 97) n = $urandom_range(41, 223);
    else n = $urandom_range(224, 255);
    d = ($urandom_range(0, 9) == 0) ? 8'hff : 8'($urandom);
    if ($urandom_range(0, 9) == 0) send_item(pay_item(8'($urandom)));
    send_item(hdr_item(3'($urandom), 24'($urandom), d, 8'(n)));
    if (n > 40) cut = $urandom_range(0, 12);
    else if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, n);
    else cut = n;
    for (int k = 0; k < cut; k++) begin
      b = 8'($urandom);
      if ($urandom_range(0, 4) == 0) b = tx_cfg.esc;
      if (k == n - 1 && $urandom_range(0, 3) == 0) b = csum_hits_esc();
      send_item(pay_item(b));
    end
  endtask

  task automatic test_random_traffic();
    int stop_at;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_reg(CFG_ESC, 8'h00);
        1: write_reg(CFG_ESC, 8'hff);
        2: write_reg(CFG_ESC, 8'($urandom));
        default: write_reg(CFG_ESC, ESC_RST);
      endcase
      write_reg(CFG_START, 8'($urandom));
      write_reg(CFG_ETX, 8'($urandom));
      write_reg(CFG_MSG, (p == 2) ? tx_cfg.esc : 8'($urandom));
      tx_quiet = (p == 1);
      rx_quiet = (p == 1) || (p == 3);
      stop_at = items_sent + 48;
      while (items_sent < stop_at) random_frame();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_receiver_hold();
    drain();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    tx_quiet = 1'b1;
    send_item(hdr_item(3'd2, 24'h010203, 8'h10, 8'd16));
    for (int k = 0; k < 16; k++) send_item(pay_item(8'($urandom)));
    tx_quiet = 1'b0;
    drain();
  endtask

  always @(posedge clk) begin
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      rx_wait <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (wire_q.size() == 0) begin
        report("unexpected byte", m_axis_tdata, 8'h00);
      end else begin
        wire_exp = wire_q.pop_front();
        if (m_axis_tdata != wire_exp.out_byte)
          report("out_byte", m_axis_tdata, wire_exp.out_byte);
        if (m_axis_tlast != wire_exp.last_in_run)
          report("last_in_run", m_axis_tlast, wire_exp.last_in_run);
        if (m_axis_tuser != wire_exp.frame_end)
          report("frame_end", m_axis_tuser, wire_exp.frame_end);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tx_cfg.tx_en = TX_EN_RST;
    tx_cfg.esc   = ESC_RST;
    tx_cfg.start = START_RST;
    tx_cfg.etx   = ETX_RST;
    tx_cfg.msg   = MSG_RST;
    run_sum      = 8'd0;
    bytes_due    = 8'd0;
    in_frame     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_default_frames();
    test_config_extremes();
    test_transmit_disabled();
    test_payload_saturation();
    test_random_traffic();
    test_receiver_hold();
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
